// ===== design/key_value_table_swap_remove_defines.svh =====
// ---------------------------------------------------------------------------
// Key/value table assertion macros
// Shared concurrent assertion forms for the key/value table.
// ---------------------------------------------------------------------------
`ifndef KEY_VALUE_TABLE_SWAP_REMOVE_DEFINES_SVH
`define KEY_VALUE_TABLE_SWAP_REMOVE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define KVT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define KVT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/kvt_pkg.sv =====
// ---------------------------------------------------------------------------
// Key/value table package
// Field widths, opcodes and status codes of the key/value table.
// ---------------------------------------------------------------------------
package kvt_pkg;

  localparam int OPCODE_W = 2;
  localparam int KEY_W    = 32;
  localparam int VALUE_W  = 64;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  localparam logic [OPCODE_W-1:0] OP_GET = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_PUT = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_DEL = 2'd2;

  localparam logic [STATUS_W-1:0] ST_FOUND    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISSING  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

endpackage

// ===== design/kvt_req_if.sv =====
// ---------------------------------------------------------------------------
// Key/value table request channel
// Valid/ready channel carrying opcode, key and value.
// ---------------------------------------------------------------------------
interface kvt_req_if import kvt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [KEY_W-1:0]    key;
  logic [VALUE_W-1:0]  value_in;

  modport source (output valid, output opcode, output key, output value_in, input ready);
  modport sink   (input valid, input opcode, input key, input value_in, output ready);
endinterface

// ===== design/kvt_rsp_if.sv =====
// ---------------------------------------------------------------------------
// Key/value table response channel
// Valid/ready channel carrying status, value and entry count.
// ---------------------------------------------------------------------------
interface kvt_rsp_if import kvt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [VALUE_W-1:0]  value_out;
  logic [COUNT_W-1:0]  entry_count;

  modport source (output valid, output status, output value_out, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input value_out, input entry_count,
                  output ready);
endinterface

// ===== design/key_value_table_swap_remove.sv =====
// Operation: get and put scan the entries linearly, up to the entry count, then
// answer from S_DONE; delete of a present key passes S_DEL_RD and S_DEL_WR first.
// Throughput: one request at a time, taken only in S_IDLE; S_DONE waits while the
// response is stalled. The scan uses the single read port of the key/value storage.
// Reset: synchronous, active low; clears the entry count and handshakes, the
// storage arrays are not cleared and need no clearing pass.
// ---------------------------------------------------------------------------
// Key/value table with swap-remove
// Packed table scanned linearly; delete moves the last entry into the hole.
// ---------------------------------------------------------------------------
`include "key_value_table_swap_remove_defines.svh"

module key_value_table_swap_remove import kvt_pkg::*; #(
  parameter int CAPACITY = 64,
  parameter int KEY_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  kvt_req_if.sink   in_req,
  kvt_rsp_if.source out_rsp
);

  localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam int STATE_W = 3;
  localparam logic [STATE_W-1:0] S_IDLE   = 3'd0;
  localparam logic [STATE_W-1:0] S_SCAN   = 3'd1;
  localparam logic [STATE_W-1:0] S_DEL_RD = 3'd2;
  localparam logic [STATE_W-1:0] S_DEL_WR = 3'd3;
  localparam logic [STATE_W-1:0] S_DONE   = 3'd4;

  logic [STATE_W-1:0]  state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic                pend_r, pend_nxt;
  logic [OPCODE_W-1:0] op_r, op_nxt;
  logic [KW-1:0]       key_r, key_nxt;
  logic [VALUE_W-1:0]  val_r, val_nxt;
  logic [AW-1:0]       slot_r, slot_nxt;
  logic [VALUE_W-1:0]  hitval_r, hitval_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [VALUE_W-1:0]  res_value_r, res_value_nxt;
  logic [CW-1:0]       res_count_r, res_count_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [VALUE_W-1:0]  out_value_r, out_value_nxt;
  logic [COUNT_W-1:0]  out_count_r, out_count_nxt;

  logic                wr_key_en, wr_val_en;
  logic [AW-1:0]       wr_addr, rd_addr;
  logic [KW-1:0]       wr_key, rd_key;
  logic [VALUE_W-1:0]  wr_val, rd_val;
  logic                hit;

  kvt_store #(
    .DEPTH (CAPACITY),
    .KW    (KW),
    .VW    (VALUE_W),
    .AW    (AW)
  ) u_store (
    .clk       (clk),
    .wr_key_en (wr_key_en),
    .wr_val_en (wr_val_en),
    .wr_addr   (wr_addr),
    .wr_key    (wr_key),
    .wr_val    (wr_val),
    .rd_addr   (rd_addr),
    .rd_key    (rd_key),
    .rd_val    (rd_val)
  );

  assign rd_addr = (state_r == S_DEL_RD) ? AW'(count_r - CW'(1)) : idx_r[AW-1:0];
  assign hit     = pend_r && (rd_key == key_r);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    pend_nxt       = pend_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    slot_nxt       = slot_r;
    hitval_nxt     = hitval_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    res_count_nxt  = res_count_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_count_nxt  = out_count_r;
    wr_key_en      = 1'b0;
    wr_val_en      = 1'b0;
    wr_addr        = slot_r;
    wr_key         = rd_key;
    wr_val         = rd_val;

    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          op_nxt    = in_req.opcode;
          key_nxt   = in_req.key[KW-1:0];
          val_nxt   = in_req.value_in;
          idx_nxt   = '0;
          pend_nxt  = 1'b0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        priority if (hit) begin
          slot_nxt       = AW'(idx_r - CW'(1));
          hitval_nxt     = rd_val;
          pend_nxt       = 1'b0;
          res_status_nxt = ST_FOUND;
          res_count_nxt  = count_r;
          state_nxt      = S_DONE;
          unique case (op_r)
            OP_GET: begin
              res_value_nxt = rd_val;
            end
            OP_PUT: begin
              wr_val_en     = 1'b1;
              wr_addr       = AW'(idx_r - CW'(1));
              wr_val        = val_r;
              res_value_nxt = val_r;
            end
            OP_DEL: begin
              state_nxt = S_DEL_RD;
            end
            default: begin
              res_status_nxt = ST_MISSING;
              res_value_nxt  = '0;
            end
          endcase
        end else if (idx_r < count_r) begin
          idx_nxt  = idx_r + CW'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt       = 1'b0;
          res_status_nxt = ST_MISSING;
          res_value_nxt  = '0;
          res_count_nxt  = count_r;
          state_nxt      = S_DONE;
          if (op_r == OP_PUT) begin
            if (count_r < CW'(CAPACITY)) begin
              wr_key_en      = 1'b1;
              wr_val_en      = 1'b1;
              wr_addr        = count_r[AW-1:0];
              wr_key         = key_r;
              wr_val         = val_r;
              count_nxt      = count_r + CW'(1);
              res_status_nxt = ST_INSERTED;
              res_value_nxt  = val_r;
              res_count_nxt  = count_r + CW'(1);
            end else begin
              res_status_nxt = ST_FULL;
            end
          end
        end
      end
      S_DEL_RD: begin
        state_nxt = S_DEL_WR;
      end
      S_DEL_WR: begin
        wr_key_en      = 1'b1;
        wr_val_en      = 1'b1;
        count_nxt      = count_r - CW'(1);
        res_status_nxt = ST_FOUND;
        res_value_nxt  = hitval_r;
        res_count_nxt  = count_r - CW'(1);
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_value_nxt  = res_value_r;
          out_count_nxt  = COUNT_W'(res_count_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    slot_r       <= slot_nxt;
    hitval_r     <= hitval_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    res_count_r  <= res_count_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign in_req.ready        = (state_r == S_IDLE);
  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status      = out_status_r;
  assign out_rsp.value_out   = out_value_r;
  assign out_rsp.entry_count = out_count_r;

  `KVT_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(CAPACITY), "count overflow")
  `KVT_ASSERT_IMP(a_scan_bound, clk, rst_n, state_r == S_SCAN, idx_r <= count_r, "scan overrun")
  `KVT_ASSERT_NXT(a_count_hold, clk, rst_n, state_r != S_SCAN && state_r != S_DEL_WR, $stable(count_r), "count moved outside commit")

endmodule

// ===== design/kvt_store.sv =====
// ---------------------------------------------------------------------------
// Key/value table storage
// Key and value arrays, one write port, one registered read port.
// ---------------------------------------------------------------------------
module kvt_store #(
  parameter int DEPTH = 64,
  parameter int KW    = 32,
  parameter int VW    = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_key_en,
  input  logic          wr_val_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [KW-1:0] wr_key,
  input  logic [VW-1:0] wr_val,
  input  logic [AW-1:0] rd_addr,
  output logic [KW-1:0] rd_key,
  output logic [VW-1:0] rd_val
);

  logic [KW-1:0] key_mem [DEPTH];
  logic [VW-1:0] val_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_key_en) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (wr_val_en) begin
      val_mem[wr_addr] <= wr_val;
    end
    rd_key <= key_mem[rd_addr];
    rd_val <= val_mem[rd_addr];
  end

endmodule

// ===== verif/testbench.sv =====
// ---------------------------------------------------------------------------
// Key/value table testbench
// Drives get, put and delete requests into the swap-remove table and checks
// every response against an in-bench table model. A directed opening covers
// empty, extreme-key, overwrite and swap-on-delete cases. Random rounds then
// fill, churn and drain the table so that it runs full repeatedly. Both
// channels idle at random. The response side also holds off for long
// stretches; the sender waits for quiet after rounds 3, 7, 11 and so on.
// ---------------------------------------------------------------------------
module testbench;
  import kvt_pkg::*;

  localparam int TABLE_DEPTH  = 64;
  localparam int RANDOM_ITEMS = 1430;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SETTLE       = 100;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [KEY_W-1:0]    key;
    logic [VALUE_W-1:0]  value;
  } kv_request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  value;
    logic [COUNT_W-1:0]  count;
  } kv_reply_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  kvt_req_if in_req ();
  kvt_rsp_if out_rsp ();

  key_value_table_swap_remove #(.CAPACITY(TABLE_DEPTH), .KEY_BITS(KEY_W)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .out_rsp(out_rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Table model
  logic [KEY_W-1:0]   kv_keys [TABLE_DEPTH];
  logic [VALUE_W-1:0] kv_vals [TABLE_DEPTH];
  int                 kv_count = 0;

  kv_request_t pending [$];
  kv_reply_t   awaited [$];
  logic [KEY_W-1:0] gen_live [$];

  int issued   = 0;
  int accepted = 0;
  int replies  = 0;
  int errors   = 0;
  int cycles   = 0;
  int hold_left  = 0;
  int holds_done = 0;
  int op_seen [4];
  int status_seen [4];
  int peak_count = 0;

  function automatic kv_reply_t kv_apply(input logic [OPCODE_W-1:0] op,
                                         input logic [KEY_W-1:0] key,
                                         input logic [VALUE_W-1:0] val);
    kv_reply_t r;
    int hit;
    int last;
    hit = -1;
    r.status = ST_MISSING;
    r.value  = '0;
    for (int i = 0; i < kv_count; i++)
      if (hit < 0 && kv_keys[i] == key) hit = i;
    case (op)
      OP_GET: begin
        if (hit >= 0) begin
          r.status = ST_FOUND;
          r.value  = kv_vals[hit];
        end
      end
      OP_PUT: begin
        if (hit >= 0) begin
          kv_vals[hit] = val;
          r.status = ST_FOUND;
          r.value  = val;
        end else if (kv_count < TABLE_DEPTH) begin
          kv_keys[kv_count] = key;
          kv_vals[kv_count] = val;
          kv_count++;
          r.status = ST_INSERTED;
          r.value  = val;
        end else begin
          r.status = ST_FULL;
        end
      end
      OP_DEL: begin
        if (hit >= 0) begin
          last = kv_count - 1;
          r.status = ST_FOUND;
          r.value  = kv_vals[hit];
          kv_keys[hit]  = kv_keys[last];
          kv_vals[hit]  = kv_vals[last];
          kv_keys[last] = '0;
          kv_vals[last] = '0;
          kv_count = last;
        end
      end
      default: ;
    endcase
    r.count = kv_count[COUNT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                 input logic [VALUE_W-1:0] want);
    $display("MISMATCH cycle %0d reply %0d: %s got %h want %h", cycles, replies, what,
             got, want);
    errors++;
  endtask

  // Stimulus helpers
  function automatic int live_index(input logic [KEY_W-1:0] key);
    for (int i = 0; i < gen_live.size(); i++)
      if (gen_live[i] == key) return i;
    return -1;
  endfunction

  task automatic push_request(input logic [OPCODE_W-1:0] op, input logic [KEY_W-1:0] key,
                              input logic [VALUE_W-1:0] val);
    kv_request_t r;
    int idx;
    r.opcode = op;
    r.key    = key;
    r.value  = val;
    pending.push_back(r);
    idx = live_index(key);
    if (op == OP_PUT && idx < 0 && gen_live.size() < TABLE_DEPTH) gen_live.push_back(key);
    else if (op == OP_DEL && idx >= 0) gen_live.delete(idx);
  endtask

  function automatic logic [KEY_W-1:0] pick_key(input int hit_pct);
    if (gen_live.size() != 0 && $urandom_range(99) < hit_pct)
      return gen_live[$urandom_range(gen_live.size() - 1)];
    else if ($urandom_range(3) == 0)
      return $urandom_range(15);
    else
      return $urandom;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic wait_quiet();
    while (pending.size() != 0 || issued != accepted || awaited.size() != 0)
      @(negedge clk);
  endtask

  function automatic bit calm_stretch();
    return accepted >= 800 && accepted < 1050;
  endfunction

  // Request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_req.valid <= 1'b0;
    end else if (!in_req.valid || accepted == issued) begin
      if (pending.size() != 0 && (calm_stretch() || $urandom_range(99) >= 9)) begin
        kv_request_t r;
        r = pending.pop_front();
        issued++;
        in_req.valid    <= 1'b1;
        in_req.opcode   <= r.opcode;
        in_req.key      <= r.key;
        in_req.value_in <= r.value;
      end else begin
        in_req.valid <= 1'b0;
      end
    end
  end

  // Response ready, with long hold-offs while requests keep coming
  always @(negedge clk) begin
    if (!rst_n) begin
      out_rsp.ready <= 1'b0;
    end else begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if (holds_done < 2 && accepted >= 350 * (holds_done + 1) &&
                   pending.size() >= 10) begin
        hold_left  <= 500;
        holds_done <= holds_done + 1;
      end
      out_rsp.ready <= hold_left == 0 && (calm_stretch() || $urandom_range(99) >= 9);
    end
  end

  // Monitor: predict on request, check on response
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_req.valid && in_req.ready) begin
        awaited.push_back(kv_apply(in_req.opcode, in_req.key, in_req.value_in));
        accepted++;
        op_seen[in_req.opcode]++;
        if (kv_count > peak_count) peak_count = kv_count;
      end
      if (out_rsp.valid && out_rsp.ready) begin
        replies++;
        if (awaited.size() == 0) begin
          report_mismatch("response with no request outstanding, value", out_rsp.value_out,
                          '0);
        end else begin
          kv_reply_t want;
          want = awaited.pop_front();
          status_seen[want.status]++;
          if (out_rsp.status !== want.status)
            report_mismatch("status", VALUE_W'(out_rsp.status), VALUE_W'(want.status));
          if (out_rsp.value_out !== want.value)
            report_mismatch("value_out", out_rsp.value_out, want.value);
          if (out_rsp.entry_count !== want.count)
            report_mismatch("entry_count", VALUE_W'(out_rsp.entry_count),
                            VALUE_W'(want.count));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d responses outstanding", cycles,
               awaited.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int round;
    int queued;
    int len;
    int roll;
    int hit;
    logic [OPCODE_W-1:0] op;

    in_req.valid     = 1'b0;
    in_req.opcode    = OP_GET;
    in_req.key       = '0;
    in_req.value_in  = '0;
    out_rsp.ready    = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, extreme keys and values, overwrite, swap-remove
    push_request(OP_GET, 32'h0000_0000, '1);
    push_request(OP_DEL, 32'h0000_0000, '1);
    push_request(OP_PUT, 32'h0000_0000, '0);
    push_request(OP_PUT, 32'hFFFF_FFFF, '1);
    push_request(OP_PUT, 32'h8000_0001, 64'hA5A5_A5A5_0F0F_F0F0);
    push_request(OP_GET, 32'h0000_0000, '1);
    push_request(OP_GET, 32'hFFFF_FFFF, '0);
    push_request(OP_GET, 32'h1234_5678, '0);
    push_request(OP_PUT, 32'h0000_0000, 64'h5A5A_5A5A_F0F0_0F0F);
    push_request(OP_GET, 32'h0000_0000, '0);
    push_request(OP_DEL, 32'hFFFF_FFFF, '0);
    push_request(OP_GET, 32'h8000_0001, '0);
    push_request(OP_GET, 32'hFFFF_FFFF, '0);
    push_request(OP_DEL, 32'h8000_0001, '0);
    push_request(OP_DEL, 32'h8000_0001, '0);
    push_request(OP_PUT, 32'h8000_0001, 64'h0123_4567_89AB_CDEF);
    push_request(OP_DEL, 32'h0000_0000, '0);
    push_request(OP_DEL, 32'h8000_0001, '0);
    push_request(OP_GET, 32'h0000_0000, '0);
    wait_quiet();

    // Random rounds: fill, churn, drain
    round  = 0;
    queued = 0;
    while (queued < RANDOM_ITEMS) begin
      len = (round % 3 == 0) ? $urandom_range(110, 160) : $urandom_range(60, 120);
      for (int n = 0; n < len && queued < RANDOM_ITEMS; n++) begin
        roll = $urandom_range(99);
        case (round % 3)
          0: begin
            op  = roll < 85 ? OP_PUT : (roll < 95 ? OP_GET : OP_DEL);
            hit = op == OP_PUT ? 10 : 80;
          end
          1: begin
            op  = roll < 40 ? OP_GET : (roll < 70 ? OP_PUT : OP_DEL);
            hit = 70;
          end
          default: begin
            op  = roll < 75 ? OP_DEL : (roll < 90 ? OP_GET : OP_PUT);
            hit = 85;
          end
        endcase
        push_request(op, pick_key(hit), pick_value());
        queued++;
      end
      round++;
      if (round % 4 == 3) wait_quiet();
    end

    wait_quiet();
    repeat (SETTLE) @(negedge clk);
    if (awaited.size() != 0)
      report_mismatch("responses never returned, count", VALUE_W'(awaited.size()), '0);

    $display("Ran %0d requests (%0d get, %0d put, %0d delete), peak occupancy %0d of %0d",
             accepted, op_seen[OP_GET], op_seen[OP_PUT], op_seen[OP_DEL], peak_count,
             TABLE_DEPTH);
    $display("Responses: %0d found, %0d missing, %0d inserted, %0d full; %0d mismatches",
             status_seen[ST_FOUND], status_seen[ST_MISSING], status_seen[ST_INSERTED],
             status_seen[ST_FULL], errors);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/kvt_pkg.sv
design/kvt_req_if.sv
design/kvt_rsp_if.sv
design/kvt_store.sv
design/key_value_table_swap_remove.sv
verif/testbench.sv
